>>> design/dda_keyframe_interpolator_bank_core_assert.svh
// ----------------------------------------------------------------------------
// dda keyframe interpolator bank - assertion macros
// shared concurrent check forms used by the block's modules
// ----------------------------------------------------------------------------
`ifndef DDA_KEYFRAME_INTERPOLATOR_BANK_CORE_ASSERT_SVH
`define DDA_KEYFRAME_INTERPOLATOR_BANK_CORE_ASSERT_SVH

// check that holds on every edge out of reset
`define DKIB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on what reset leaves behind in the cycle after it
`define DKIB_ASSERT_AFTER_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) !rst_n |=> prop) else $error(msg);

`endif

>>> design/dkib_pkg.sv
// ----------------------------------------------------------------------------
// dkib_pkg
// types, codes and constants shared by the interpolator bank modules
// ----------------------------------------------------------------------------
`default_nettype none

package dkib_pkg;

  localparam int ACT_W   = 2;
  localparam int BONE_W  = 6;
  localparam int ELEM_W  = 4;
  localparam int HALF_W  = 16;
  localparam int VALUE_W = 32;

  localparam int BONE_COUNT_DEF = 64;
  localparam int ELEM_COUNT     = 9;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SET  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STEP = 2'd2;

  // element groups within a bone
  localparam logic [ELEM_W-1:0] ROT_FIRST = 4'd3;
  localparam logic [ELEM_W-1:0] LOC_FIRST = 4'd6;
  localparam logic [ELEM_W-1:0] LAST_ELEM = 4'd8;

  // one channel entry of the bank
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [HALF_W-1:0]  whole;
    logic [HALF_W-1:0]  rem;
    logic [HALF_W-1:0]  down;
    logic [HALF_W-1:0]  reload;
    logic               sign;
  } chan_word_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

  typedef struct packed {
    logic [HALF_W-1:0] quot;
    logic [HALF_W-1:0] rem_mag;
    logic              neg;
  } div_res_t;

  typedef struct packed {
    logic [VALUE_W-1:0] new_value;
    logic               changed;
    logic               status;
  } res_t;

endpackage

`default_nettype wire

>>> design/dkib_if.sv
// ----------------------------------------------------------------------------
// dkib channel interfaces
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface dkib_in_if;
  logic                              valid;
  logic                              ready;
  logic [dkib_pkg::ACT_W-1:0]        action;
  logic [dkib_pkg::BONE_W-1:0]       bone;
  logic [dkib_pkg::ELEM_W-1:0]       element;
  logic signed [dkib_pkg::HALF_W-1:0]  amount;
  logic signed [dkib_pkg::HALF_W-1:0]  divisor;
  logic signed [dkib_pkg::VALUE_W-1:0] start_value;

  modport source (output valid, action, bone, element, amount, divisor, start_value,
                  input ready);
  modport sink   (input valid, action, bone, element, amount, divisor, start_value,
                  output ready);
endinterface

interface dkib_out_if;
  logic                                valid;
  logic                                ready;
  logic [dkib_pkg::BONE_W-1:0]         out_bone;
  logic [dkib_pkg::ELEM_W-1:0]         out_element;
  logic signed [dkib_pkg::VALUE_W-1:0] new_value;
  logic                                changed;
  logic                                status;
  logic                                last;

  modport source (output valid, out_bone, out_element, new_value, changed, status, last,
                  input ready);
  modport sink   (input valid, out_bone, out_element, new_value, changed, status, last,
                  output ready);
endinterface

`default_nettype wire

>>> design/dkib_div.sv
// ----------------------------------------------------------------------------
// dkib_div
// restoring signed divider, one quotient bit per cycle, truncating toward zero
// ----------------------------------------------------------------------------
`default_nettype none

`include "dda_keyframe_interpolator_bank_core_assert.svh"

module dkib_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [dkib_pkg::HALF_W-1:0]   dividend,
  input  wire logic [dkib_pkg::HALF_W-1:0]   divisor,
  output logic                               done,
  output dkib_pkg::div_res_t                 res
);

  localparam int W     = dkib_pkg::HALF_W;
  localparam int CNT_W = $clog2(W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     quot_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     dvs_r;
  logic             qneg_r;
  logic             aneg_r;

  logic [W-1:0]     a_mag;
  logic [W-1:0]     d_mag;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;

  // magnitude of -32768 is 0x8000 as unsigned
  assign a_mag = dividend[W-1] ? W'(-dividend) : dividend;
  assign d_mag = divisor[W-1]  ? W'(-divisor)  : divisor;

  assign trial = {rem_r, quot_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = !diff[W];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W - 1);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= a_mag;
      rem_r  <= '0;
      dvs_r  <= d_mag;
      qneg_r <= dividend[W-1] ^ divisor[W-1];
      aneg_r <= dividend[W-1];
    end else if (busy_r) begin
      quot_r <= {quot_r[W-2:0], ge};
      rem_r  <= ge ? diff[W-1:0] : trial[W-1:0];
    end
  end

  // quotient wraps to 16 bits, remainder takes the dividend's sign
  assign done        = done_r;
  assign res.quot    = qneg_r ? W'(-quot_r) : quot_r;
  assign res.rem_mag = rem_r;
  assign res.neg     = aneg_r;

  `DKIB_ASSERT(a_done_after_busy, clk, rst_n, done_r |-> $past(busy_r), "divider done without run")

endmodule

`default_nettype wire

>>> design/dkib_bank.sv
// ----------------------------------------------------------------------------
// dkib_bank
// channel memory, one read and one write port, cleared by a sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none

`include "dda_keyframe_interpolator_bank_core_assert.svh"

module dkib_bank #(
  parameter int BONE_COUNT = dkib_pkg::BONE_COUNT_DEF,
  localparam int DEPTH     = BONE_COUNT * dkib_pkg::ELEM_COUNT,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dkib_pkg::mem_ctrl_t  ctrl,
  input  wire logic [AW-1:0]        rd_addr,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire dkib_pkg::chan_word_t wr_data,
  output dkib_pkg::chan_word_t      rd_data,
  output logic                      clr_busy
);

  dkib_pkg::chan_word_t mem [DEPTH];
  dkib_pkg::chan_word_t rd_data_r;

  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

  `DKIB_ASSERT(a_no_wr_in_clear, clk, rst_n, ctrl.wr_en |-> !clr_busy_r, "write during clear sweep")
  `DKIB_ASSERT_AFTER_RST(a_rst_starts_clear, clk, rst_n, clr_busy_r && clr_addr_r == '0, "reset did not start clear sweep")

endmodule

`default_nettype wire

>>> design/dkib_update.sv
// ----------------------------------------------------------------------------
// dkib_update
// per-channel modify step: set, rate load and dda step of one entry
// ----------------------------------------------------------------------------
`default_nettype none

module dkib_update (
  input  wire logic [dkib_pkg::ACT_W-1:0]   act,
  input  wire logic [dkib_pkg::BONE_W-1:0]  bone,
  input  wire logic [dkib_pkg::ELEM_W-1:0]  elem,
  input  wire logic [dkib_pkg::VALUE_W-1:0] start_value,
  input  wire logic [dkib_pkg::HALF_W-1:0]  divisor,
  input  wire dkib_pkg::div_res_t           div_res,
  input  wire dkib_pkg::chan_word_t         old_w,
  output dkib_pkg::chan_word_t              new_w,
  output logic                              wr_en,
  output dkib_pkg::res_t                    res
);

  localparam int HW = dkib_pkg::HALF_W;
  localparam int VW = dkib_pkg::VALUE_W;

  logic [VW-1:0] whole_ext;
  logic [VW-1:0] base_sum;
  logic [VW-1:0] step_sum;
  logic [VW-1:0] step_val;
  logic [HW-1:0] cnt_dif;
  logic [HW-1:0] cnt_wrap;
  logic          has_rem;
  logic          tick;
  logic          rot;
  logic          active;
  logic          skip;

  assign whole_ext = {{(VW-HW){old_w.whole[HW-1]}}, old_w.whole};
  assign base_sum  = old_w.value + whole_ext;
  assign cnt_dif   = old_w.down - old_w.rem;
  assign cnt_wrap  = cnt_dif + old_w.reload;
  assign has_rem   = old_w.rem != '0;
  // counter at or below zero after taking the remainder
  assign tick      = has_rem && (cnt_dif[HW-1] || cnt_dif == '0);
  assign step_sum  = !tick      ? base_sum :
                     old_w.sign ? base_sum - 1'b1 : base_sum + 1'b1;
  assign rot       = elem >= dkib_pkg::ROT_FIRST && elem < dkib_pkg::LOC_FIRST;
  assign step_val  = rot ? {{(VW-HW){step_sum[HW-1]}}, step_sum[HW-1:0]} : step_sum;
  assign active    = old_w.whole != '0 || has_rem;
  // root bone location is not moved
  assign skip      = bone == '0 && elem >= dkib_pkg::LOC_FIRST;

  always_comb begin
    new_w         = old_w;
    wr_en         = 1'b0;
    res.new_value = old_w.value;
    res.changed   = 1'b0;
    res.status    = 1'b0;
    unique case (act)
      dkib_pkg::ACT_SET: begin
        new_w.value   = start_value;
        wr_en         = 1'b1;
        res.new_value = start_value;
      end
      dkib_pkg::ACT_LOAD: begin
        if (divisor == '0) begin
          res.status = 1'b1;
        end else begin
          wr_en       = 1'b1;
          new_w.whole = div_res.quot;
          if (div_res.rem_mag != '0) begin
            new_w.rem    = div_res.rem_mag;
            new_w.sign   = div_res.neg;
            new_w.reload = divisor;
            new_w.down   = divisor;
          end else begin
            new_w.rem = '0;
          end
        end
      end
      dkib_pkg::ACT_STEP: begin
        if (active && !skip) begin
          wr_en         = 1'b1;
          new_w.value   = step_val;
          res.new_value = step_val;
          res.changed   = 1'b1;
          if (has_rem) begin
            new_w.down = tick ? cnt_wrap : cnt_dif;
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/dda_keyframe_interpolator_bank_core.sv
// ----------------------------------------------------------------------------
// dda_keyframe_interpolator_bank_core
// Bank of BONE_COUNT x 9 fractional-step interpolation channels kept in one
// single-port-read, single-port-write memory. A set word and a load word each
// give one result word; a step word gives nine, one per element of the bone,
// at one result per cycle while the result side takes them (read of the next
// entry overlaps the update and write of the current one). in_chan.ready stays
// low until the last result word of the current word is registered for the
// result side, so a new word is not taken while one is in progress. A load with
// a nonzero divisor first runs the radix-2 divider, 16 iterations, and then
// reads and updates its entry. A result side that holds ready low stalls the
// pipe. Words with an unknown action or an address out of range are taken and
// dropped. After reset the memory is swept to zero, and in_chan.ready stays low
// for that time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dda_keyframe_interpolator_bank_core_assert.svh"

module dda_keyframe_interpolator_bank_core #(
  parameter int BONE_COUNT = dkib_pkg::BONE_COUNT_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dkib_in_if.sink     in_chan,
  dkib_out_if.source  out_chan
);

  localparam int DEPTH  = BONE_COUNT * dkib_pkg::ELEM_COUNT;
  localparam int AW     = $clog2(DEPTH);
  localparam int FULL_W = dkib_pkg::BONE_W + dkib_pkg::ELEM_W;
  localparam int BCMP_W = dkib_pkg::BONE_W + 1;
  localparam int EW     = dkib_pkg::ELEM_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [dkib_pkg::ACT_W-1:0]   act_r;
  logic [dkib_pkg::BONE_W-1:0]  bone_r;
  logic [dkib_pkg::VALUE_W-1:0] start_r;
  logic [dkib_pkg::HALF_W-1:0]  divisor_r;

  logic [EW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [EW-1:0] rd_elem_r, rd_elem_nxt;
  logic          pipe_v_r, pipe_v_nxt;
  logic [EW-1:0] pipe_elem_r;
  logic [AW-1:0] pipe_addr_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [dkib_pkg::BONE_W-1:0]  out_bone_r;
  logic [EW-1:0]                out_elem_r;
  logic [dkib_pkg::VALUE_W-1:0] out_value_r;
  logic                         out_changed_r;
  logic                         out_status_r;
  logic                         out_last_r;

  logic              in_ready;
  logic              in_fire;
  logic              item_ok;
  logic              is_step;
  logic              div_start;
  logic              div_done;
  logic              issue;
  logic              cons;
  logic [FULL_W-1:0] addr_full;
  logic [AW-1:0]     rd_addr;
  logic              clr_busy;
  logic              upd_wr_en;

  dkib_pkg::mem_ctrl_t  mem_ctrl;
  dkib_pkg::chan_word_t rd_word;
  dkib_pkg::chan_word_t wr_word;
  dkib_pkg::div_res_t   div_res;
  dkib_pkg::res_t       upd_res;

  // -- command decode
  assign in_ready  = state_r == ST_IDLE && !clr_busy;
  assign in_fire   = in_chan.valid && in_ready;
  assign is_step   = in_chan.action == dkib_pkg::ACT_STEP;
  assign item_ok   = ({1'b0, in_chan.bone} < BCMP_W'(BONE_COUNT)) &&
                     (is_step ||
                      ((in_chan.action == dkib_pkg::ACT_SET ||
                        in_chan.action == dkib_pkg::ACT_LOAD) &&
                       in_chan.element <= dkib_pkg::LAST_ELEM));
  assign div_start = in_fire && item_ok && in_chan.action == dkib_pkg::ACT_LOAD &&
                     in_chan.divisor != '0;

  // -- read / modify / write pipe
  assign cons    = pipe_v_r && (!out_valid_r || out_chan.ready);
  assign issue   = state_r == ST_RUN && rd_cnt_r != '0 && (!pipe_v_r || cons);
  assign addr_full = FULL_W'({bone_r, 3'b000}) + FULL_W'(bone_r) + FULL_W'(rd_elem_r);
  assign rd_addr   = addr_full[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    rd_cnt_nxt  = rd_cnt_r;
    rd_elem_nxt = rd_elem_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && item_ok) begin
          state_nxt   = div_start ? ST_DIV : ST_RUN;
          rd_cnt_nxt  = is_step ? EW'(dkib_pkg::ELEM_COUNT) : EW'(1);
          rd_elem_nxt = is_step ? '0 : in_chan.element;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          rd_cnt_nxt  = rd_cnt_r - 1'b1;
          rd_elem_nxt = rd_elem_r + 1'b1;
        end
        if (cons && rd_cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign pipe_v_nxt    = issue || (pipe_v_r && !cons);
  assign out_valid_nxt = cons || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      rd_elem_r   <= '0;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_elem_r   <= rd_elem_nxt;
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r     <= in_chan.action;
      bone_r    <= in_chan.bone;
      start_r   <= in_chan.start_value;
      divisor_r <= in_chan.divisor;
    end
    if (issue) begin
      pipe_elem_r <= rd_elem_r;
      pipe_addr_r <= rd_addr;
    end
    if (cons) begin
      out_bone_r    <= bone_r;
      out_elem_r    <= pipe_elem_r;
      out_value_r   <= upd_res.new_value;
      out_changed_r <= upd_res.changed;
      out_status_r  <= upd_res.status;
      out_last_r    <= rd_cnt_r == '0;
    end
  end

  assign mem_ctrl.rd_en = issue;
  assign mem_ctrl.wr_en = cons && upd_wr_en;

  dkib_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_chan.amount),
    .divisor  (in_chan.divisor),
    .done     (div_done),
    .res      (div_res)
  );

  dkib_bank #(
    .BONE_COUNT (BONE_COUNT)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mem_ctrl),
    .rd_addr  (rd_addr),
    .wr_addr  (pipe_addr_r),
    .wr_data  (wr_word),
    .rd_data  (rd_word),
    .clr_busy (clr_busy)
  );

  dkib_update u_update (
    .act         (act_r),
    .bone        (bone_r),
    .elem        (pipe_elem_r),
    .start_value (start_r),
    .divisor     (divisor_r),
    .div_res     (div_res),
    .old_w       (rd_word),
    .new_w       (wr_word),
    .wr_en       (upd_wr_en),
    .res         (upd_res)
  );

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_bone    = out_bone_r;
  assign out_chan.out_element = out_elem_r;
  assign out_chan.new_value   = out_value_r;
  assign out_chan.changed     = out_changed_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.last        = out_last_r;

  `DKIB_ASSERT(a_pipe_in_run, clk, rst_n, pipe_v_r |-> state_r == ST_RUN, "read data pending outside run")
  `DKIB_ASSERT(a_last_to_idle, clk, rst_n, (cons && rd_cnt_r == '0) |=> state_r == ST_IDLE, "last word did not end item")
  `DKIB_ASSERT(a_div_done_in_div, clk, rst_n, div_done |-> state_r == ST_DIV, "divider done outside divide wait")

endmodule

`default_nettype wire

>>> test/tb_dda_keyframe_interpolator_bank_core.sv
// ----------------------------------------------------------------------------
// tb_dda_keyframe_interpolator_bank_core
// Self-checking bench for the keyframe interpolator bank. Command words go in
// through the valid/ready command channel while a local model of every channel
// (value, quotient, remainder, counter, sign) predicts the result words. A
// checker compares each result word, field by field, against the oldest
// prediction. Directed words cover extremes, zero divisors, quotient wrap,
// rotation wrap, root location and dropped words; random traffic follows,
// concentrated on a few bones so steps keep walking loaded channels.
// ----------------------------------------------------------------------------
module tb_dda_keyframe_interpolator_bank_core;

  localparam int BONES       = 64;
  localparam int CHANS       = BONES * dkib_pkg::ELEM_COUNT;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_SLACK = 40;

  localparam logic [dkib_pkg::ACT_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct {
    logic [dkib_pkg::BONE_W-1:0]  bone;
    logic [dkib_pkg::ELEM_W-1:0]  elem;
    logic [dkib_pkg::VALUE_W-1:0] value;
    logic                         changed;
    logic                         status;
    logic                         last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dkib_in_if  cmd_if ();
  dkib_out_if res_if ();

  dda_keyframe_interpolator_bank_core #(
    .BONE_COUNT(BONES)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (cmd_if),
    .out_chan(res_if)
  );

  always #6 clk = ~clk;

  // local copy of the channel table
  logic        [dkib_pkg::VALUE_W-1:0] chan_value [CHANS];
  logic signed [dkib_pkg::HALF_W-1:0]  whole_step [CHANS];
  logic        [dkib_pkg::HALF_W-1:0]  rem_mag    [CHANS];
  logic signed [dkib_pkg::HALF_W-1:0]  down_cnt   [CHANS];
  logic signed [dkib_pkg::HALF_W-1:0]  reload_cnt [CHANS];
  logic                                step_neg   [CHANS];

  result_word_t pending_results[$];

  bit gapless = 1'b0;
  int err_cnt = 0;
  int n_set = 0;
  int n_load = 0;
  int n_step = 0;
  int n_dropped = 0;
  int n_checked = 0;

  function automatic void push_result(input logic [dkib_pkg::BONE_W-1:0] b,
                                      input logic [dkib_pkg::ELEM_W-1:0] el,
                                      input logic [dkib_pkg::VALUE_W-1:0] val, input logic chg,
                                      input logic st, input logic lst);
    result_word_t w;
    w.bone    = b;
    w.elem    = el;
    w.value   = val;
    w.changed = chg;
    w.status  = st;
    w.last    = lst;
    pending_results.push_back(w);
  endfunction

  // updates the channel table for one accepted word and queues its results
  function automatic void predict_channels(input logic [dkib_pkg::ACT_W-1:0] act,
                                           input logic [dkib_pkg::BONE_W-1:0] b,
                                           input logic [dkib_pkg::ELEM_W-1:0] el,
                                           input logic signed [dkib_pkg::HALF_W-1:0] amt,
                                           input logic signed [dkib_pkg::HALF_W-1:0] dv,
                                           input logic [dkib_pkg::VALUE_W-1:0] sv);
    int idx;
    int quo;
    int rmd;
    logic [dkib_pkg::VALUE_W-1:0] acc;
    logic signed [dkib_pkg::HALF_W-1:0] cnt;
    logic chg;
    if (act == ACT_UNKNOWN || b >= BONES) return;
    if (act == dkib_pkg::ACT_STEP) begin
      for (int e = 0; e < dkib_pkg::ELEM_COUNT; e++) begin
        idx = b * dkib_pkg::ELEM_COUNT + e;
        acc = chan_value[idx];
        chg = 1'b0;
        // root bone keeps its location still
        if ((whole_step[idx] != 0 || rem_mag[idx] != 0) &&
            !(b == 0 && e >= dkib_pkg::LOC_FIRST)) begin
          acc = acc + {{(dkib_pkg::VALUE_W-dkib_pkg::HALF_W){
                          whole_step[idx][dkib_pkg::HALF_W-1]}}, whole_step[idx]};
          if (rem_mag[idx] != 0) begin
            cnt = down_cnt[idx] - rem_mag[idx];
            if (cnt <= 0) begin
              cnt = cnt + reload_cnt[idx];
              acc = step_neg[idx] ? acc - 1 : acc + 1;
            end
            down_cnt[idx] = cnt;
          end
          if (e >= dkib_pkg::ROT_FIRST && e < dkib_pkg::LOC_FIRST)
            acc = {{(dkib_pkg::VALUE_W-dkib_pkg::HALF_W){acc[dkib_pkg::HALF_W-1]}},
                   acc[dkib_pkg::HALF_W-1:0]};
          chan_value[idx] = acc;
          chg = 1'b1;
        end
        push_result(b, dkib_pkg::ELEM_W'(e), acc, chg, 1'b0, e == dkib_pkg::LAST_ELEM);
      end
      return;
    end
    if (el >= dkib_pkg::ELEM_COUNT) return;
    idx = b * dkib_pkg::ELEM_COUNT + el;
    if (act == dkib_pkg::ACT_SET) begin
      chan_value[idx] = sv;
      push_result(b, el, sv, 1'b0, 1'b0, 1'b1);
    end else if (dv == 0) begin
      push_result(b, el, chan_value[idx], 1'b0, 1'b1, 1'b1);
    end else begin
      quo = int'(amt) / int'(dv);
      rmd = int'(amt) % int'(dv);
      whole_step[idx] = quo[dkib_pkg::HALF_W-1:0];
      if (rmd != 0) begin
        step_neg[idx]   = rmd < 0;
        rem_mag[idx]    = dkib_pkg::HALF_W'(rmd < 0 ? -rmd : rmd);
        reload_cnt[idx] = dv;
        down_cnt[idx]   = dv;
      end else begin
        rem_mag[idx] = '0;
      end
      push_result(b, el, chan_value[idx], 1'b0, 1'b0, 1'b1);
    end
  endfunction

  // drives one command word and waits for it to be taken; valid stays high
  // afterwards so a back-to-back word needs no extra edge
  task automatic send_word(input logic [dkib_pkg::ACT_W-1:0] act,
                           input logic [dkib_pkg::BONE_W-1:0] b,
                           input logic [dkib_pkg::ELEM_W-1:0] el,
                           input logic signed [dkib_pkg::HALF_W-1:0] amt,
                           input logic signed [dkib_pkg::HALF_W-1:0] dv,
                           input logic [dkib_pkg::VALUE_W-1:0] sv);
    if (!gapless && $urandom_range(99) < 13) begin
      cmd_if.valid       <= 1'b0;
      cmd_if.action      <= dkib_pkg::ACT_W'($urandom);
      cmd_if.bone        <= dkib_pkg::BONE_W'($urandom);
      cmd_if.element     <= dkib_pkg::ELEM_W'($urandom);
      cmd_if.amount      <= dkib_pkg::HALF_W'($urandom);
      cmd_if.divisor     <= dkib_pkg::HALF_W'($urandom);
      cmd_if.start_value <= $urandom;
      @(posedge clk);
      while ($urandom_range(99) < 45) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.action      <= act;
    cmd_if.bone        <= b;
    cmd_if.element     <= el;
    cmd_if.amount      <= amt;
    cmd_if.divisor     <= dv;
    cmd_if.start_value <= sv;
    @(posedge clk);
    while (cmd_if.ready !== 1'b1) @(posedge clk);
    predict_channels(act, b, el, amt, dv, sv);
    if (act == dkib_pkg::ACT_STEP)
      n_step++;
    else if (act == ACT_UNKNOWN || el >= dkib_pkg::ELEM_COUNT)
      n_dropped++;
    else if (act == dkib_pkg::ACT_SET)
      n_set++;
    else
      n_load++;
  endtask

  task automatic hold_until_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic test_set_extremes();
    send_word(dkib_pkg::ACT_SET, 6'd63, dkib_pkg::LAST_ELEM, 16'sh7FFF, 16'sh8000,
              32'h7FFF_FFFF);
    send_word(dkib_pkg::ACT_SET, 6'd0, 4'd0, 16'sh8000, 16'sh7FFF, 32'h8000_0000);
    send_word(dkib_pkg::ACT_SET, 6'd5, dkib_pkg::ROT_FIRST, '0, '0, 32'h0000_7FFF);
    send_word(dkib_pkg::ACT_SET, 6'd0, dkib_pkg::LOC_FIRST, '1, '1, 32'hFFFF_FFFF);
  endtask

  task automatic test_load_rates();
    send_word(dkib_pkg::ACT_LOAD, 6'd5, dkib_pkg::ROT_FIRST, 16'sd1, 16'sd1, $urandom);
    send_word(dkib_pkg::ACT_LOAD, 6'd63, dkib_pkg::LAST_ELEM, 16'sd7, 16'sd3, $urandom);
    // quotient overflows back to the most negative value
    send_word(dkib_pkg::ACT_LOAD, 6'd0, 4'd0, 16'sh8000, -16'sd1, $urandom);
    send_word(dkib_pkg::ACT_LOAD, 6'd0, dkib_pkg::LOC_FIRST, 16'sd100, 16'sd7, $urandom);
    send_word(dkib_pkg::ACT_LOAD, 6'd7, 4'd4, -16'sd7, 16'sd3, $urandom);
    send_word(dkib_pkg::ACT_LOAD, 6'd7, 4'd5, 16'sd5, 16'sh8000, $urandom);
    send_word(dkib_pkg::ACT_LOAD, 6'd7, 4'd0, 16'sh7FFF, 16'sd0, $urandom);
    send_word(dkib_pkg::ACT_LOAD, 6'd7, 4'd1, 16'sh8000, 16'sh7FFF, $urandom);
  endtask

  task automatic test_step_walks();
    send_word(dkib_pkg::ACT_STEP, 6'd5, 4'd0, '0, '0, $urandom);
    send_word(dkib_pkg::ACT_STEP, 6'd63, 4'hF, '1, '1, $urandom);
    send_word(dkib_pkg::ACT_STEP, 6'd0, dkib_pkg::LAST_ELEM, '0, '0, $urandom);
    repeat (3) send_word(dkib_pkg::ACT_STEP, 6'd7, dkib_pkg::ELEM_W'($urandom), '0, '0,
                         $urandom);
    send_word(dkib_pkg::ACT_STEP, 6'd12, 4'd0, '0, '0, $urandom);
  endtask

  task automatic test_dropped_words();
    send_word(ACT_UNKNOWN, 6'd7, 4'd4, 16'sd3, 16'sd2, $urandom);
    send_word(dkib_pkg::ACT_SET, 6'd7, 4'd9, '0, '0, 32'h1234_5678);
    send_word(dkib_pkg::ACT_LOAD, 6'd7, 4'hF, 16'sd9, 16'sd2, $urandom);
    // a following walk shows the dropped words left bone 7 alone
    send_word(dkib_pkg::ACT_STEP, 6'd7, 4'd0, '0, '0, $urandom);
  endtask

  task automatic test_random_traffic(input int n_words, input bit no_gaps);
    int done;
    int pick;
    int h;
    logic [dkib_pkg::ACT_W-1:0] act;
    logic [dkib_pkg::BONE_W-1:0] b;
    logic [dkib_pkg::ELEM_W-1:0] el;
    logic signed [dkib_pkg::HALF_W-1:0] amt;
    logic signed [dkib_pkg::HALF_W-1:0] dv;
    gapless = no_gaps;
    done = 0;
    while (done < n_words) begin
      pick = $urandom_range(99);
      // most traffic lands on bones 0-3 and 60-63 so walks meet loaded channels
      h = $urandom_range(9);
      if (h < 8)
        b = (h < 4) ? dkib_pkg::BONE_W'(h) : dkib_pkg::BONE_W'(56 + h);
      else
        b = dkib_pkg::BONE_W'($urandom);
      el = dkib_pkg::ELEM_W'($urandom_range(dkib_pkg::ELEM_COUNT - 1));
      if ($urandom_range(3) == 0)
        amt = dkib_pkg::HALF_W'($urandom);
      else
        amt = dkib_pkg::HALF_W'(int'($urandom_range(400)) - 200);
      case ($urandom_range(19))
        0:       dv = '0;
        1, 2:    dv = dkib_pkg::HALF_W'($urandom);
        3:       dv = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        default: dv = dkib_pkg::HALF_W'(int'($urandom_range(24, 1)) *
                                         ($urandom_range(1) ? 1 : -1));
      endcase
      if (pick < 18) begin
        act = dkib_pkg::ACT_SET;
      end else if (pick < 52) begin
        act = dkib_pkg::ACT_LOAD;
      end else if (pick < 90) begin
        act = dkib_pkg::ACT_STEP;
        el  = dkib_pkg::ELEM_W'($urandom);
      end else if (pick < 95) begin
        act = ACT_UNKNOWN;
      end else begin
        act = $urandom_range(1) ? dkib_pkg::ACT_SET : dkib_pkg::ACT_LOAD;
        el  = dkib_pkg::ELEM_W'($urandom_range(15, dkib_pkg::ELEM_COUNT));
      end
      send_word(act, b, el, amt, dv, $urandom);
      done++;
    end
    gapless = 1'b0;
  endtask

  // result side backpressure
  always @(posedge clk) begin
    res_if.ready <= gapless || ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin : check_results
    result_word_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: bone %0d element %0d value %0d",
               res_if.out_bone, res_if.out_element, res_if.new_value);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (res_if.out_bone !== want.bone) begin
          $error("out_bone expected %0d got %0d", want.bone, res_if.out_bone);
          err_cnt++;
        end
        if (res_if.out_element !== want.elem) begin
          $error("out_element expected %0d got %0d", want.elem, res_if.out_element);
          err_cnt++;
        end
        if (res_if.new_value !== want.value) begin
          $error("new_value expected %0d got %0d", $signed(want.value), res_if.new_value);
          err_cnt++;
        end
        if (res_if.changed !== want.changed) begin
          $error("changed expected %0d got %0d", want.changed, res_if.changed);
          err_cnt++;
        end
        if (res_if.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, res_if.status);
          err_cnt++;
        end
        if (res_if.last !== want.last) begin
          $error("last expected %0d got %0d", want.last, res_if.last);
          err_cnt++;
        end
      end
    end
  end

  // ends the run if neither side moves a word for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no word moved for %0d cycles, %0d results pending", STALL_LIMIT,
           pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < CHANS; i++) begin
      chan_value[i] = '0;
      whole_step[i] = '0;
      rem_mag[i]    = '0;
      down_cnt[i]   = '0;
      reload_cnt[i] = '0;
      step_neg[i]   = 1'b0;
    end
    cmd_if.valid       <= 1'b0;
    cmd_if.action      <= '0;
    cmd_if.bone        <= '0;
    cmd_if.element     <= '0;
    cmd_if.amount      <= '0;
    cmd_if.divisor     <= '0;
    cmd_if.start_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_set_extremes();
    test_load_rates();
    test_step_walks();
    test_dropped_words();
    hold_until_drained();
    test_random_traffic(300, 1'b0);
    hold_until_drained();
    test_random_traffic(120, 1'b1);
    test_random_traffic(30, 1'b0);
    hold_until_drained();

    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      err_cnt++;
    end
    $display("sent %0d set, %0d load, %0d step and %0d dropped words", n_set, n_load, n_step,
             n_dropped);
    $display("checked %0d result words, %0d mismatches", n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
